// ===== rtl/core/s2i_pkg.sv =====
// Shared types, codes and tables for the serial to two-wire command decoder.
package s2i_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [1:0] OK_RESP = 2'd0;
  localparam logic [1:0] OK_REQ  = 2'd1;
  localparam logic [1:0] OK_DIV  = 2'd2;

  localparam logic [7:0] STATUS_OK  = 8'h00;
  localparam logic [7:0] STATUS_ERR = 8'hFF;

  localparam logic [3:0] CMD_DIV_HI = 4'h8;
  localparam logic [4:0] DIV_RESET  = 5'd29;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      status;
    logic [7:0]      addr;
    logic [1:0]      count;
    logic [2:0][7:0] data;
    logic [4:0]      div;
    logic [1:0]      nrd;
  } s2i_job_t;

  typedef struct packed {
    logic     valid;
    s2i_job_t job;
  } s2i_head_t;

  function automatic logic [4:0] div_lookup(input logic [1:0] sel);
    logic [4:0] r;
    case (sel)
      2'd0: r = DIV_RESET;
      2'd1: r = 5'd6;
      2'd2: r = 5'd2;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/s2i_front.sv =====
// Front end: accepts words, keeps decoder state and builds result jobs.
module s2i_front import s2i_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic       ack_ok_i,
  input  logic [7:0] read_byte0_i,
  input  logic [7:0] read_byte1_i,
  input  logic [7:0] read_byte2_i,
  output logic       push_o,
  output s2i_job_t   job_o
);

  logic [7:0]      addr_q, addr_d;
  logic [2:0][7:0] data_q, data_d;
  logic            pending_q, pending_d;
  logic [1:0]      psize_q, psize_d;

  logic [2:0] sel;
  logic [3:0] nib;
  logic [1:0] size;
  logic [7:0] addr_m;
  logic [2:0][7:0] data_m;
  logic       rd_ok;
  logic [1:0] nrd;
  logic [2:0][7:0] rd_bytes;

  assign sel      = rx_byte_i[6:4];
  assign nib      = rx_byte_i[3:0];
  assign rd_bytes = {read_byte2_i, read_byte1_i, read_byte0_i};
  assign rd_ok    = ack_ok_i & addr_q[0];
  assign nrd      = rd_ok ? psize_q : 2'd0;

  always_comb begin
    addr_m = addr_q;
    data_m = data_q;
    case (sel)
      3'd0: addr_m[7:4]    = nib;
      3'd1: addr_m[3:0]    = nib;
      3'd2: data_m[0][7:4] = nib;
      3'd3: data_m[0][3:0] = nib;
      3'd4: data_m[1][7:4] = nib;
      3'd5: data_m[1][3:0] = nib;
      3'd6: data_m[2][7:4] = nib;
      default: data_m[2][3:0] = nib;
    endcase
    if (sel inside {3'd6, 3'd7}) begin
      size = 2'd3;
    end else if (sel inside {3'd4, 3'd5}) begin
      size = 2'd2;
    end else begin
      size = 2'd1;
    end
  end

  always_comb begin
    addr_d    = addr_q;
    data_d    = data_q;
    pending_d = pending_q;
    psize_d   = psize_q;
    push_o    = 1'b0;
    job_o     = '0;
    if (accept_i) begin
      if (!kind_i) begin
        if (!pending_q) begin
          if (rx_byte_i[7:4] == CMD_DIV_HI) begin
            if (rx_byte_i[3:2] == 2'd0) begin
              push_o     = 1'b1;
              job_o.kind = OK_DIV;
              job_o.div  = div_lookup(rx_byte_i[1:0]);
            end
          end else begin
            addr_d = addr_m;
            data_d = data_m;
            if (rx_byte_i[7]) begin
              pending_d   = 1'b1;
              psize_d     = size;
              push_o      = 1'b1;
              job_o.kind  = OK_REQ;
              job_o.addr  = addr_m;
              job_o.count = size;
              job_o.data  = data_m;
            end
          end
        end
      end else if (pending_q) begin
        pending_d    = 1'b0;
        push_o       = 1'b1;
        job_o.kind   = OK_RESP;
        job_o.status = ack_ok_i ? STATUS_OK : STATUS_ERR;
        job_o.nrd    = nrd;
        job_o.data   = rd_bytes;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < nrd) begin
            data_d[i] = rd_bytes[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      data_q    <= '0;
      pending_q <= 1'b0;
      psize_q   <= 2'd1;
    end else begin
      addr_q    <= addr_d;
      data_q    <= data_d;
      pending_q <= pending_d;
      psize_q   <= psize_d;
    end
  end

endmodule

// ===== rtl/core/s2i_fifo.sv =====
// Short job queue between the front end and the result sequencer.
module s2i_fifo import s2i_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  s2i_job_t  job_i,
  input  logic      pop_i,
  output logic      full_o,
  output s2i_head_t head_o
);

  s2i_job_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == QCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/s2i_back.sv =====
// Back end: walks the head job and emits its result words one per cycle while the output is not stalled.
module s2i_back import s2i_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  s2i_head_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] target_address_o,
  output logic [1:0] byte_count_o,
  output logic [7:0] write_byte0_o,
  output logic [7:0] write_byte1_o,
  output logic [7:0] write_byte2_o,
  output logic [4:0] clock_divider_o,
  output logic       last_o
);

  logic [1:0] idx_q, idx_d;
  logic       take;
  logic [1:0] didx;
  s2i_job_t   job;

  assign job         = head_i.job;
  assign out_valid_o = head_i.valid;
  assign take        = out_valid_o & ~out_stall_i;
  assign last_o      = (idx_q == job.nrd);
  assign pop_o       = take & last_o;
  assign didx        = idx_q - 2'd1;

  always_comb begin
    out_kind_o       = job.kind;
    out_byte_o       = '0;
    target_address_o = '0;
    byte_count_o     = '0;
    write_byte0_o    = '0;
    write_byte1_o    = '0;
    write_byte2_o    = '0;
    clock_divider_o  = '0;
    case (job.kind)
      OK_RESP: out_byte_o = (idx_q == 2'd0) ? job.status : job.data[didx];
      OK_REQ: begin
        target_address_o = job.addr;
        byte_count_o     = job.count;
        write_byte0_o    = job.data[0];
        write_byte1_o    = job.data[1];
        write_byte2_o    = job.data[2];
      end
      OK_DIV: clock_divider_o = job.div;
      default: out_byte_o = '0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/core/serial_to_i2c_command_decoder.sv =====
// Serial to two-wire command decoder top level.
// A word's results are written into the job queue and shown from its head.
// Throughput: one input word per cycle while the 4-entry job queue has room;
// results leave one per cycle while the output is not stalled, and a read completion gives up to 4 result words.
// Reset (async, active low): address and data zero, not pending, size one, queue empty.
module serial_to_i2c_command_decoder import s2i_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic       ack_ok_i,
  input  logic [7:0] read_byte0_i,
  input  logic [7:0] read_byte1_i,
  input  logic [7:0] read_byte2_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] target_address_o,
  output logic [1:0] byte_count_o,
  output logic [7:0] write_byte0_o,
  output logic [7:0] write_byte1_o,
  output logic [7:0] write_byte2_o,
  output logic [4:0] clock_divider_o,
  output logic       last_o
);

  logic      accept;
  logic      push;
  logic      pop;
  logic      full;
  s2i_job_t  job;
  s2i_head_t head;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = full;

  s2i_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .ack_ok_i     (ack_ok_i),
    .read_byte0_i (read_byte0_i),
    .read_byte1_i (read_byte1_i),
    .read_byte2_i (read_byte2_i),
    .push_o       (push),
    .job_o        (job)
  );

  s2i_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  s2i_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_byte_o       (out_byte_o),
    .target_address_o (target_address_o),
    .byte_count_o     (byte_count_o),
    .write_byte0_o    (write_byte0_o),
    .write_byte1_o    (write_byte1_o),
    .write_byte2_o    (write_byte2_o),
    .clock_divider_o  (clock_divider_o),
    .last_o           (last_o)
  );

  a_single_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != OK_RESP |-> last_o)
    else $error("request or divider word not marked last");

  a_req_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OK_REQ |-> byte_count_o != 2'd0)
    else $error("request word with zero byte count");

  a_resp_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OK_RESP && !last_o |=> out_valid_o && out_kind_o == OK_RESP)
    else $error("response sequence broken before last word");

endmodule

// ===== verif/tb_serial_to_i2c_command_decoder.sv =====
// Testbench for the serial to two-wire command decoder: scoreboard, drivers and checks.
module tb_serial_to_i2c_command_decoder import s2i_pkg::*; ();

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] resp;
    logic [7:0] addr;
    logic [1:0] count;
    logic [7:0] wb0;
    logic [7:0] wb1;
    logic [7:0] wb2;
    logic [4:0] div;
    logic       last;
  } dec_result_t;

  class decoder_scoreboard;
    logic [7:0]  addr_q;
    logic [7:0]  data_q [3];
    bit          busy;
    int unsigned busy_size;
    logic [4:0]  div_q;
    dec_result_t due_results [$];
    int unsigned failures;
    int unsigned checked;
    int unsigned requests;

    function new();
      addr_q    = 8'h00;
      data_q    = '{default: 8'h00};
      busy      = 1'b0;
      busy_size = 1;
      div_q     = DIV_RESET;
      failures  = 0;
      checked   = 0;
      requests  = 0;
    endfunction

    function string show(dec_result_t r);
      return $sformatf("kind=%0d byte=%02h addr=%02h count=%0d data=%02h/%02h/%02h div=%0d last=%0b",
                       r.kind, r.resp, r.addr, r.count, r.wb0, r.wb1, r.wb2, r.div, r.last);
    endfunction

    // Returns 1 when the word changes state or causes results.
    function bit predict_word(bit kind, bit [7:0] rx, bit ack,
                              bit [7:0] rb0, bit [7:0] rb1, bit [7:0] rb2);
      dec_result_t r;
      dec_result_t batch [$];
      bit [7:0]    rb [3];
      int unsigned sel;
      int unsigned idx;
      int unsigned size;
      r  = '0;
      rb = '{rb0, rb1, rb2};
      if (kind == 1'b0) begin
        if (busy) return 1'b0;
        if (rx[7:4] == CMD_DIV_HI) begin
          if (rx[3:2] != 2'b00) return 1'b0;
          case (rx[1:0])
            2'd0: div_q = DIV_RESET;
            2'd1: div_q = 5'd6;
            2'd2: div_q = 5'd2;
            default: div_q = 5'd0;
          endcase
          r.kind = OK_DIV;
          r.div  = div_q;
          r.last = 1'b1;
          due_results.push_back(r);
          return 1'b1;
        end
        sel = rx[6:4];
        if (sel < 2) begin
          if (sel == 0) addr_q[7:4] = rx[3:0];
          else addr_q[3:0] = rx[3:0];
        end else begin
          idx = sel / 2 - 1;
          if (sel % 2) data_q[idx][3:0] = rx[3:0];
          else data_q[idx][7:4] = rx[3:0];
        end
        size = (sel >= 6) ? 3 : (sel >= 4) ? 2 : 1;
        if (rx[7]) begin
          r.kind  = OK_REQ;
          r.addr  = addr_q;
          r.count = 2'(size);
          r.wb0   = data_q[0];
          r.wb1   = data_q[1];
          r.wb2   = data_q[2];
          r.last  = 1'b1;
          due_results.push_back(r);
          busy      = 1'b1;
          busy_size = size;
          requests++;
        end
        return 1'b1;
      end
      if (!busy) return 1'b0;
      busy   = 1'b0;
      r.kind = OK_RESP;
      r.resp = ack ? STATUS_OK : STATUS_ERR;
      batch.push_back(r);
      if (ack && addr_q[0]) begin
        for (int i = 0; i < busy_size; i++) begin
          data_q[i] = rb[i];
          r.resp    = rb[i];
          batch.push_back(r);
        end
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_results.push_back(batch[i]);
      return 1'b1;
    endfunction

    function void check_result(dec_result_t got);
      dec_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction

    function void report_leftover();
      if (due_results.size() != 0) begin
        failures++;
        $display("%0d expected results never arrived", due_results.size());
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic       kind_i       = 1'b0;
  logic [7:0] rx_byte_i    = 8'h00;
  logic       ack_ok_i     = 1'b0;
  logic [7:0] read_byte0_i = 8'h00;
  logic [7:0] read_byte1_i = 8'h00;
  logic [7:0] read_byte2_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic [7:0] target_address_o;
  logic [1:0] byte_count_o;
  logic [7:0] write_byte0_o;
  logic [7:0] write_byte1_o;
  logic [7:0] write_byte2_o;
  logic [4:0] clock_divider_o;
  logic       last_o;

  decoder_scoreboard sb = new();
  bit                quiet = 1'b0;
  int unsigned       words_sent = 0;
  int unsigned       words_used = 0;

  serial_to_i2c_command_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .rx_byte_i        (rx_byte_i),
    .ack_ok_i         (ack_ok_i),
    .read_byte0_i     (read_byte0_i),
    .read_byte1_i     (read_byte1_i),
    .read_byte2_i     (read_byte2_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_byte_o       (out_byte_o),
    .target_address_o (target_address_o),
    .byte_count_o     (byte_count_o),
    .write_byte0_o    (write_byte0_o),
    .write_byte1_o    (write_byte1_o),
    .write_byte2_o    (write_byte2_o),
    .clock_divider_o  (clock_divider_o),
    .last_o           (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("[serial_to_i2c_command_decoder] ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result monitor and random output stall
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_result('{kind: out_kind_o, resp: out_byte_o, addr: target_address_o,
                        count: byte_count_o, wb0: write_byte0_o, wb1: write_byte1_o,
                        wb2: write_byte2_o, div: clock_divider_o, last: last_o});
    end
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      stall_left  <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  task automatic idle(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_word(input bit kind, input bit [7:0] rx, input bit ack,
                           input bit [7:0] b0, input bit [7:0] b1, input bit [7:0] b2);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    rx_byte_i    <= rx;
    ack_ok_i     <= ack;
    read_byte0_i <= b0;
    read_byte1_i <= b1;
    read_byte2_i <= b2;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    if (sb.predict_word(kind, rx, ack, b0, b1, b2)) words_used++;
    idle(pick_gap());
  endtask

  task automatic send_cmd(input bit [7:0] rx);
    send_word(1'b0, rx, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_done(input bit ack, input bit [7:0] b0, input bit [7:0] b1,
                           input bit [7:0] b2);
    send_word(1'b1, 8'($urandom), ack, b0, b1, b2);
  endtask

  task automatic drain();
    idle(1);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Nibble loads, go byte, optional dropped byte, completion
  task automatic run_transfer();
    int unsigned n;
    n = $urandom_range(0, 6);
    repeat (n) send_cmd({1'b0, 3'($urandom), 4'($urandom)});
    send_cmd({1'b1, 3'($urandom_range(1, 7)), 4'($urandom)});
    if ($urandom_range(0, 4) == 0) send_cmd(8'($urandom));
    send_done($urandom_range(0, 9) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned target;
    int unsigned r;
    bit          paused;
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: dividers, ignored bytes, all nibbles, every size, dropped bytes
    send_done(1'b1, 8'h11, 8'h22, 8'h33);
    send_cmd(8'h80);
    send_cmd(8'h81);
    send_cmd(8'h82);
    send_cmd(8'h83);
    send_cmd(8'h84);
    send_cmd(8'h8F);
    send_cmd(8'h0A);
    send_cmd(8'h1B);
    send_cmd(8'h20);
    send_cmd(8'h3F);
    send_cmd(8'h4F);
    send_cmd(8'h50);
    send_cmd(8'hE5);
    send_cmd(8'h81);
    send_cmd(8'h12);
    send_done(1'b1, 8'hFF, 8'h00, 8'hA5);
    send_cmd(8'h9E);
    send_done(1'b0, 8'h00, 8'hFF, 8'h00);
    send_cmd(8'h11);
    send_cmd(8'hC3);
    send_done(1'b0, 8'h5A, 8'h5A, 8'h5A);
    send_cmd(8'hD7);
    send_done(1'b1, 8'h00, 8'hFF, 8'h77);
    send_cmd(8'hFF);
    send_done(1'b1, 8'hC3, 8'h3C, 8'hFF);
    drain();

    target = 160;
    while (words_sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) run_transfer();
      else if (r < 80) send_cmd(8'h80 | 8'($urandom_range(0, 3)));
      else if (r < 90) send_word(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
      else send_done(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      if (!paused && words_sent > target - 80) begin
        paused = 1'b1;
        drain();
      end
    end
    quiet = 1'b0;

    idle(1);
    r = 0;
    while (sb.outstanding() != 0 && r < 20000) begin
      @(posedge clk_i);
      r++;
    end
    repeat (10) @(posedge clk_i);
    sb.report_leftover();
    $display("Run covered %0d words (%0d effective), %0d bus requests, %0d results checked.",
             words_sent, words_used, sb.requests, sb.checked);
    if (sb.failures == 0) begin
      $display("[serial_to_i2c_command_decoder] OK");
    end else begin
      $display("%0d failures", sb.failures);
      $display("[serial_to_i2c_command_decoder] ERROR");
    end
    $finish;
  end

endmodule
